FILE: design/fdmr_pkg.sv
// Shared constants, types and helpers for the frame difference motion recorder.
package fdmr_pkg;

  // Frame geometry: the reference store holds one entry per pixel position.
  localparam int unsigned FRAME_PIXELS = 65536;
  localparam int unsigned ADDR_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam int unsigned IDX_W  = $clog2(FRAME_PIXELS + 1);

  localparam int unsigned CNT_W    = 23;
  localparam int unsigned THR_W    = 8;
  localparam int unsigned PHASE_W  = 8;
  localparam int unsigned HOLD_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Grey weighting of the channel differences, rounded, 14 fraction bits.
  localparam int unsigned PROD_W     = 22;
  localparam int unsigned GREY_SHIFT = 14;
  localparam logic [PROD_W-1:0] GREY_W_B   = PROD_W'(1868);
  localparam logic [PROD_W-1:0] GREY_W_G   = PROD_W'(9617);
  localparam logic [PROD_W-1:0] GREY_W_R   = PROD_W'(4899);
  localparam logic [PROD_W-1:0] GREY_ROUND = PROD_W'(8192);
  localparam logic [7:0]        GREY_CEIL  = 8'd254;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CHANGED      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_INTERVAL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_FRAMES      = 2'd3;

  localparam logic [THR_W-1:0]   RST_DIFF_THRESHOLD   = 8'd20;
  localparam logic [CNT_W-1:0]   RST_MIN_CHANGED      = 23'd50;
  localparam logic [PHASE_W-1:0] RST_COMPARE_INTERVAL = 8'd5;
  localparam logic [HOLD_W-1:0]  RST_HOLD_FRAMES      = 16'd150;

  localparam int unsigned CFG_DATA_W = CNT_W;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // Per-pixel control that travels down the pipeline with the data.
  typedef struct packed {
    logic fe;         // last pixel of its frame
    logic cmp;        // pixel is compared against the stored reference
    logic loaded;     // reference was loaded before this frame
    logic cmp_frame;  // this frame is a compare frame
  } meta_t;

  function automatic logic [7:0] abs_diff8(input logic [7:0] a, input logic [7:0] b);
    abs_diff8 = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

FILE: design/fdmr_diff_grey.sv
// Two-stage datapath: channel differences weighted to grey, then threshold test.
module fdmr_diff_grey (
  input  logic                         clk,
  input  logic                         en,
  input  fdmr_pkg::pixel_t             pix,
  input  fdmr_pkg::pixel_t             ref_pix,
  input  logic [fdmr_pkg::THR_W-1:0]   thr,
  output logic                         hit
);

  logic [fdmr_pkg::PROD_W-1:0] prod_b_r, prod_g_r, prod_r_r;
  logic [fdmr_pkg::PROD_W-1:0] grey_sum;
  logic [7:0]                  grey;
  logic [7:0]                  d_b, d_g, d_r;
  logic                        hit_r;

  assign d_b = fdmr_pkg::abs_diff8(pix.blue,  ref_pix.blue);
  assign d_g = fdmr_pkg::abs_diff8(pix.green, ref_pix.green);
  assign d_r = fdmr_pkg::abs_diff8(pix.red,   ref_pix.red);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_b_r <= fdmr_pkg::PROD_W'(d_b) * fdmr_pkg::GREY_W_B;
      prod_g_r <= fdmr_pkg::PROD_W'(d_g) * fdmr_pkg::GREY_W_G;
      prod_r_r <= fdmr_pkg::PROD_W'(d_r) * fdmr_pkg::GREY_W_R;
    end
  end

  // sum tops out just under 2^22, so grey fits in 8 bits
  assign grey_sum = prod_b_r + prod_g_r + prod_r_r + fdmr_pkg::GREY_ROUND;
  assign grey     = grey_sum[fdmr_pkg::PROD_W-1:fdmr_pkg::GREY_SHIFT];

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= (grey >= thr) && (grey <= fdmr_pkg::GREY_CEIL);
    end
  end

  assign hit = hit_r;

endmodule

FILE: design/frame_difference_motion_recorder_top.sv
// Top level of the frame difference motion recorder: reference store, pixel pipeline, recorder.
//
// Pixels enter on the in_ channel (valid/stall), one per clock while in_stall is low,
// in frame order; in_frame_end marks the last pixel of a frame. Each frame end yields
// one result on the out_ channel (valid/stall); other pixels yield none.
// The first frame after reset only loads the reference store. On every
// compare_interval-th frame each pixel is compared to its stored reference and
// then replaces it; the frame's changed count decides motion and drives the
// recording start/stop logic.
// Throughput: one pixel per clock while in_stall is low. The reference store is one
// single-port-write, registered-read memory; a pixel's read and write both happen in its
// accept cycle (read-first), so back-to-back pixels never collide. A frame's result passes
// through stages s1, s2 and s3 into the output register after its last pixel transfers.
// The output register holds a waiting result while pixels keep flowing; in_stall
// rises only when a second frame result reaches the output while the first one
// is still stalled by the receiver.
// Reset (rst_n low, synchronous) restores the register defaults and clears all control state;
// store contents are unknown, and the next frame reloads them. Configuration is written through
// cfg_ (valid/ready, always ready) by the user only while idle; the block does not enforce it.
module frame_difference_motion_recorder_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // pixel input
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_blue,
  input  logic [7:0]                       in_green,
  input  logic [7:0]                       in_red,
  input  logic                             in_frame_end,
  // frame results
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_compared,
  output logic [fdmr_pkg::CNT_W-1:0]       out_changed_pixels,
  output logic                             out_motion,
  output logic                             out_recording,
  output logic                             out_record_start,
  output logic                             out_record_stop,
  // configuration
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fdmr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fdmr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // configuration registers
  logic [fdmr_pkg::THR_W-1:0]   diff_threshold_r;
  logic [fdmr_pkg::CNT_W-1:0]   min_changed_r;
  logic [fdmr_pkg::PHASE_W-1:0] compare_interval_r;
  logic [fdmr_pkg::HOLD_W-1:0]  hold_frames_r;

  // frame tracking at the input
  logic [fdmr_pkg::IDX_W-1:0]   idx_r;
  logic                         loaded_r;
  logic [fdmr_pkg::PHASE_W-1:0] phase_r;

  // pipeline
  logic              s1_v_r, s2_v_r, s3_v_r;
  fdmr_pkg::meta_t   s1_meta_r, s2_meta_r, s3_meta_r;
  fdmr_pkg::pixel_t  s1_pix_r;
  fdmr_pkg::pixel_t  rd_r;
  logic              s3_hit;

  // frame result state
  logic [fdmr_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic                        rec_r, rec_nxt;
  logic [fdmr_pkg::HOLD_W-1:0] quiet_r, quiet_nxt;
  logic                        motion_nxt, start_nxt, stop_nxt;

  // output register
  logic                        out_valid_r;
  logic                        compared_r, motion_r, recording_r, start_r, stop_r;
  logic [fdmr_pkg::CNT_W-1:0]  changed_r;

  logic                          adv, acc, in_range, compare_now, wr_en, res_fire;
  fdmr_pkg::pixel_t              in_pix;
  fdmr_pkg::meta_t               in_meta;
  logic [fdmr_pkg::ADDR_W-1:0]   addr;

  fdmr_pkg::pixel_t ref_mem [fdmr_pkg::FRAME_PIXELS];

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_threshold_r   <= fdmr_pkg::RST_DIFF_THRESHOLD;
      min_changed_r      <= fdmr_pkg::RST_MIN_CHANGED;
      compare_interval_r <= fdmr_pkg::RST_COMPARE_INTERVAL;
      hold_frames_r      <= fdmr_pkg::RST_HOLD_FRAMES;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fdmr_pkg::CFG_DIFF_THRESHOLD:   diff_threshold_r   <= cfg_data[fdmr_pkg::THR_W-1:0];
        fdmr_pkg::CFG_MIN_CHANGED:      min_changed_r      <= cfg_data[fdmr_pkg::CNT_W-1:0];
        fdmr_pkg::CFG_COMPARE_INTERVAL: compare_interval_r <= cfg_data[fdmr_pkg::PHASE_W-1:0];
        fdmr_pkg::CFG_HOLD_FRAMES:      hold_frames_r      <= cfg_data[fdmr_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- input stage
  // pipeline moves unless a frame result would land on a stalled output register
  assign adv      = !(s3_v_r && s3_meta_r.fe && out_valid_r && out_stall);
  assign in_stall = !adv;
  assign acc      = in_valid && adv;

  assign in_pix      = '{red: in_red, green: in_green, blue: in_blue};
  assign in_range    = idx_r < fdmr_pkg::IDX_W'(fdmr_pkg::FRAME_PIXELS);
  assign compare_now = (phase_r == compare_interval_r);
  assign wr_en       = in_range && (!loaded_r || compare_now);
  assign addr        = idx_r[fdmr_pkg::ADDR_W-1:0];

  assign in_meta.fe        = in_frame_end;
  assign in_meta.cmp       = in_range && loaded_r && compare_now;
  assign in_meta.loaded    = loaded_r;
  assign in_meta.cmp_frame = compare_now;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      loaded_r <= 1'b0;
      phase_r  <= fdmr_pkg::PHASE_W'(1);
    end else if (acc) begin
      if (in_frame_end) begin
        idx_r <= '0;
        if (!loaded_r) begin
          loaded_r <= 1'b1;
        end else if (compare_now) begin
          phase_r <= fdmr_pkg::PHASE_W'(1);
        end else begin
          phase_r <= phase_r + fdmr_pkg::PHASE_W'(1);
        end
      end else if (in_range) begin
        idx_r <= idx_r + fdmr_pkg::IDX_W'(1);
      end
    end
  end

  // reference store: read-first, so a pixel sees the entry from the last frame that stored one
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_r <= ref_mem[addr];
      if (wr_en) begin
        ref_mem[addr] <= in_pix;
      end
    end
  end

  // ---------------------------------------------------------------- pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= acc;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_meta_r <= in_meta;
      s1_pix_r  <= in_pix;
      s2_meta_r <= s1_meta_r;
      s3_meta_r <= s2_meta_r;
    end
  end

  fdmr_diff_grey u_diff_grey (
    .clk     (clk),
    .en      (adv),
    .pix     (s1_pix_r),
    .ref_pix (rd_r),
    .thr     (diff_threshold_r),
    .hit     (s3_hit)
  );

  // ---------------------------------------------------------------- frame result
  assign res_fire = adv && s3_v_r && s3_meta_r.fe;

  always_comb begin
    count_nxt = count_r;
    if (s3_meta_r.cmp && s3_hit && (count_r != fdmr_pkg::CNT_MAX)) begin
      count_nxt = count_r + fdmr_pkg::CNT_W'(1);
    end

    motion_nxt = 1'b0;
    start_nxt  = 1'b0;
    stop_nxt   = 1'b0;
    rec_nxt    = rec_r;
    quiet_nxt  = quiet_r;
    if (s3_meta_r.loaded) begin
      motion_nxt = s3_meta_r.cmp_frame && (count_nxt > min_changed_r);
      if (motion_nxt) begin
        quiet_nxt = fdmr_pkg::HOLD_W'(1);
        if (!rec_r) begin
          rec_nxt   = 1'b1;
          start_nxt = 1'b1;
        end
      end
      if (rec_nxt) begin
        if (quiet_nxt < hold_frames_r) begin
          quiet_nxt = quiet_nxt + fdmr_pkg::HOLD_W'(1);
        end else begin
          rec_nxt  = 1'b0;
          stop_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rec_r   <= 1'b0;
      quiet_r <= fdmr_pkg::RST_HOLD_FRAMES;
    end else if (adv && s3_v_r) begin
      if (s3_meta_r.fe) begin
        count_r <= '0;
        rec_r   <= rec_nxt;
        quiet_r <= quiet_nxt;
      end else begin
        count_r <= count_nxt;
      end
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      compared_r  <= s3_meta_r.loaded && s3_meta_r.cmp_frame;
      changed_r   <= (s3_meta_r.loaded && s3_meta_r.cmp_frame) ? count_nxt : '0;
      motion_r    <= motion_nxt;
      recording_r <= rec_nxt;
      start_r     <= start_nxt;
      stop_r      <= stop_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_compared       = compared_r;
  assign out_changed_pixels = changed_r;
  assign out_motion         = motion_r;
  assign out_recording      = recording_r;
  assign out_record_start   = start_r;
  assign out_record_stop    = stop_r;

`ifndef SYNTHESIS
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= fdmr_pkg::IDX_W'(fdmr_pkg::FRAME_PIXELS))
    else $error("pixel index ran past the frame size");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall && s3_v_r && s3_meta_r.fe))
    else $error("input stalled without a blocked frame result");

  a_start_needs_motion: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_record_start) |-> out_motion)
    else $error("recording started without motion");

  a_stop_clears_rec: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_record_stop) |-> !out_recording)
    else $error("recording still active after stop");

  a_uncompared_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_compared) |-> (out_changed_pixels == '0 && !out_motion))
    else $error("count or motion reported on a frame that was not compared");
`endif

endmodule

FILE: tb/sv/motion_result_checker.sv
// Monitor and predictor for the motion recorder: tracks every transfer and checks frame results.
`timescale 1ns / 100ps
module motion_result_checker
  import fdmr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [7:0]            in_blue,
  input  logic [7:0]            in_green,
  input  logic [7:0]            in_red,
  input  logic                  in_frame_end,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  out_compared,
  input  logic [CNT_W-1:0]      out_changed_pixels,
  input  logic                  out_motion,
  input  logic                  out_recording,
  input  logic                  out_record_start,
  input  logic                  out_record_stop,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int unsigned           pending_results,
  output int unsigned           fail_count
);

  // luma weights of the channel differences, 14 fraction bits
  localparam int unsigned WEIGHT_BLUE  = 1868;
  localparam int unsigned WEIGHT_GREEN = 9617;
  localparam int unsigned WEIGHT_RED   = 4899;
  localparam int unsigned ROUND_HALF   = 8192;
  localparam int unsigned GREY_FRAC    = 14;
  localparam logic [7:0]  GREY_TOP     = 8'd254;

  typedef struct packed {
    logic             compared;
    logic [CNT_W-1:0] changed_pixels;
    logic             motion;
    logic             recording;
    logic             record_start;
    logic             record_stop;
  } frame_result_t;

  pixel_t           ref_store [FRAME_PIXELS];
  logic [IDX_W-1:0] pix_pos;
  logic [CNT_W-1:0] changed_cnt;
  logic             ref_loaded;
  logic [PHASE_W-1:0] phase;
  logic             rec_active;
  logic [HOLD_W-1:0] quiet_cnt;

  logic [THR_W-1:0]   thr_reg;
  logic [CNT_W-1:0]   min_reg;
  logic [PHASE_W-1:0] interval_reg;
  logic [HOLD_W-1:0]  hold_reg;

  frame_result_t expected_frames [$];

  function automatic logic [7:0] chan_gap(logic [7:0] a, logic [7:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [7:0] grey_gap(pixel_t cur, pixel_t old);
    int unsigned sum;
    sum = chan_gap(cur.blue, old.blue) * WEIGHT_BLUE
        + chan_gap(cur.green, old.green) * WEIGHT_GREEN
        + chan_gap(cur.red, old.red) * WEIGHT_RED;
    return 8'((sum + ROUND_HALF) >> GREY_FRAC);
  endfunction

  task automatic apply_pixel(pixel_t px, logic last);
    frame_result_t res;
    logic          cmp_now;
    logic          moved;
    logic [7:0]    grey;
    cmp_now = (phase == interval_reg);
    // pixels past the frame size are neither compared nor stored
    if (pix_pos < FRAME_PIXELS) begin
      if (!ref_loaded) begin
        ref_store[pix_pos[ADDR_W-1:0]] = px;
      end else if (cmp_now) begin
        grey = grey_gap(px, ref_store[pix_pos[ADDR_W-1:0]]);
        if (grey >= thr_reg && grey <= GREY_TOP && changed_cnt != CNT_MAX) begin
          changed_cnt++;
        end
        ref_store[pix_pos[ADDR_W-1:0]] = px;
      end
      pix_pos++;
    end
    if (last) begin
      res = '0;
      if (!ref_loaded) begin
        ref_loaded = 1'b1;
      end else begin
        moved = cmp_now && (changed_cnt > min_reg);
        if (moved) begin
          quiet_cnt = 1;
          if (!rec_active) begin
            rec_active = 1'b1;
            res.record_start = 1'b1;
          end
        end
        // start and stop fall on one frame when hold is 1
        if (rec_active) begin
          if (quiet_cnt < hold_reg) begin
            quiet_cnt++;
          end else begin
            rec_active = 1'b0;
            res.record_stop = 1'b1;
          end
        end
        res.compared = cmp_now;
        res.changed_pixels = cmp_now ? changed_cnt : '0;
        res.motion = moved;
        phase = cmp_now ? PHASE_W'(1) : phase + PHASE_W'(1);
      end
      res.recording = rec_active;
      expected_frames.push_back(res);
      pix_pos = '0;
      changed_cnt = '0;
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result();
    frame_result_t want;
    if (expected_frames.size() == 0) begin
      $error("frame result transfer with no frame end pending");
      fail_count++;
    end else begin
      want = expected_frames.pop_front();
      check_field("compared", want.compared, out_compared);
      check_field("changed_pixels", want.changed_pixels, out_changed_pixels);
      check_field("motion", want.motion, out_motion);
      check_field("recording", want.recording, out_recording);
      check_field("record_start", want.record_start, out_record_start);
      check_field("record_stop", want.record_stop, out_record_stop);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      thr_reg = RST_DIFF_THRESHOLD;
      min_reg = RST_MIN_CHANGED;
      interval_reg = RST_COMPARE_INTERVAL;
      hold_reg = RST_HOLD_FRAMES;
      pix_pos = '0;
      changed_cnt = '0;
      ref_loaded = 1'b0;
      phase = PHASE_W'(1);
      rec_active = 1'b0;
      quiet_cnt = RST_HOLD_FRAMES;
      expected_frames.delete();
      fail_count = 0;
      pending_results <= 0;
    end else begin
      // results first: a result never belongs to a pixel taken on the same edge
      if (out_valid && !out_stall) begin
        check_result();
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DIFF_THRESHOLD:   thr_reg = cfg_data[THR_W-1:0];
          CFG_MIN_CHANGED:      min_reg = cfg_data[CNT_W-1:0];
          CFG_COMPARE_INTERVAL: interval_reg = cfg_data[PHASE_W-1:0];
          CFG_HOLD_FRAMES:      hold_reg = cfg_data[HOLD_W-1:0];
        endcase
      end
      if (in_valid && !in_stall) begin
        apply_pixel({in_red, in_green, in_blue}, in_frame_end);
      end
      pending_results <= expected_frames.size();
    end
  end

endmodule

FILE: tb/sv/frame_difference_motion_recorder_top_tb.sv
// Testbench top for the motion recorder: clock, reset, pixel stimulus, register writes, verdict.
`timescale 1ns / 100ps
module frame_difference_motion_recorder_top_tb;
  import fdmr_pkg::*;

  localparam int unsigned SCENE_N        = 16;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned RANDOM_PHASES  = 8;
  localparam int unsigned PHASE_ITEMS    = 150;
  localparam int unsigned WRAP_ITEMS     = 270;
  // longest later frame is the noise frame of LOAD_PIXELS; random frames reach 16 plus 16 more
  localparam int unsigned LOAD_PIXELS    = 40;

  typedef enum {SCENE_STILL, SCENE_MOVING, SCENE_NOISE} scene_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_blue = '0;
  logic [7:0]            in_green = '0;
  logic [7:0]            in_red = '0;
  logic                  in_frame_end = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_compared;
  logic [CNT_W-1:0]      out_changed_pixels;
  logic                  out_motion;
  logic                  out_recording;
  logic                  out_record_start;
  logic                  out_record_stop;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned pending_results;
  int unsigned fail_count;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;
  int unsigned frame_pos = 0;
  pixel_t      scene [SCENE_N];

  frame_difference_motion_recorder_top DUT (.*);

  motion_result_checker result_check (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // ends the run when no transfer of any kind happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_pixel(pixel_t px, logic last);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_blue <= px.blue;
    in_green <= px.green;
    in_red <= px.red;
    in_frame_end <= last;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_frame(int unsigned len, bit close, scene_mode_t mode);
    pixel_t px;
    bit     last;
    for (int unsigned k = 0; k < len; k++) begin
      last = close && (k == len - 1);
      if (frame_pos < SCENE_N && mode != SCENE_NOISE) begin
        if (mode == SCENE_MOVING && $urandom_range(1) == 1) begin
          scene[frame_pos] = 24'($urandom());
        end
        // scene pixel with only small sensor noise on each channel
        px = scene[frame_pos];
        px.blue = px.blue ^ 8'($urandom_range(3));
        px.green = px.green ^ 8'($urandom_range(3));
        px.red = px.red ^ 8'($urandom_range(3));
      end else begin
        px = 24'($urandom());
      end
      send_pixel(px, last);
      frame_pos = last ? 0 : frame_pos + 1;
    end
  endtask

  // waits for every frame result, then lets the pixel pipeline drain
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_regs(logic [THR_W-1:0] thr, logic [CNT_W-1:0] min_cnt,
                          logic [PHASE_W-1:0] intv, logic [HOLD_W-1:0] hold);
    put_reg(CFG_DIFF_THRESHOLD, CFG_DATA_W'(thr));
    put_reg(CFG_MIN_CHANGED, CFG_DATA_W'(min_cnt));
    put_reg(CFG_COMPARE_INTERVAL, CFG_DATA_W'(intv));
    put_reg(CFG_HOLD_FRAMES, CFG_DATA_W'(hold));
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(int unsigned items, int unsigned max_len, bit may_leave_open);
    int unsigned sent;
    int unsigned len;
    bit          close;
    scene_mode_t mode;
    sent = 0;
    while (sent < items) begin
      len = $urandom_range(1, max_len);
      // an open frame carries over the register writes of the next phase
      close = !(may_leave_open && sent + len >= items && $urandom_range(2) == 0);
      case ($urandom_range(9))
        0:       mode = SCENE_NOISE;
        1, 2, 3: mode = SCENE_MOVING;
        default: mode = SCENE_STILL;
      endcase
      send_frame(len, close, mode);
      sent += len;
    end
  endtask

  initial begin
    pixel_t             probe [4];
    logic [THR_W-1:0]   thr;
    logic [CNT_W-1:0]   min_cnt;
    logic [PHASE_W-1:0] intv;
    logic [HOLD_W-1:0]  hold;
    int unsigned        max_len;

    for (int i = 0; i < SCENE_N; i++) begin
      scene[i] = 24'($urandom());
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // loading frame covers every position that a later frame reaches
    send_frame(LOAD_PIXELS, 1'b1, SCENE_NOISE);
    settle();
    set_regs(8'd1, '0, 8'd1, 16'd1);

    for (int k = 0; k < 4; k++) begin
      send_pixel('0, k == 3);
    end
    // grey differences of 255, 0, 254 and 1 against the black reference
    probe[0] = {3{8'hFF}};
    probe[1] = '0;
    probe[2] = {3{8'hFE}};
    probe[3] = {3{8'h01}};
    for (int k = 0; k < 4; k++) begin
      send_pixel(probe[k], k == 3);
    end
    for (int k = 0; k < 4; k++) begin
      send_pixel(probe[k], k == 3);
    end

    // register writes in the middle of a frame
    send_pixel('0, 1'b0);
    send_pixel(24'($urandom()), 1'b0);
    settle();
    set_regs(8'd255, '0, 8'd1, 16'd3);
    send_pixel(24'($urandom()), 1'b0);
    send_pixel(24'($urandom()), 1'b1);

    // compared frame with the changed-pixel threshold at 2^22 and hold at its largest
    settle();
    set_regs(8'd20, CNT_W'(4194304), 8'd1, 16'hFFFF);
    send_frame(LOAD_PIXELS, 1'b1, SCENE_NOISE);

    // move the frame counter to 2, then drop the interval below it
    settle();
    set_regs(8'd20, '0, 8'd3, 16'd2);
    send_pixel(24'($urandom()), 1'b1);
    settle();
    set_regs(8'd12, '0, 8'd1, 16'd2);

    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 50; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 50; end
        default: begin gap_pct = 27; stall_pct = 27; end
      endcase
      if (p == 0) begin
        run_phase(WRAP_ITEMS, 1, 1'b0);
      end else begin
        settle();
        case ($urandom_range(5))
          0:       thr = 8'd1;
          1:       thr = 8'd255;
          default: thr = 8'($urandom_range(8, 80));
        endcase
        min_cnt = ($urandom_range(7) == 0) ? CNT_W'(4194304) : CNT_W'($urandom_range(6));
        intv = ($urandom_range(7) == 0) ? 8'd255 : 8'($urandom_range(1, 4));
        hold = ($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom_range(1, 5));
        set_regs(thr, min_cnt, intv, hold);
        max_len = (intv > 8) ? 2 : 16;
        run_phase(PHASE_ITEMS, max_len, p != RANDOM_PHASES - 1);
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/fdmr_pkg.sv
design/fdmr_diff_grey.sv
design/frame_difference_motion_recorder_top.sv
tb/sv/motion_result_checker.sv
tb/sv/frame_difference_motion_recorder_top_tb.sv
